@@ hw/rtl/oaht_pkg.sv @@
// Shared types and constants for the open-addressing hash table core.
// Depends on nothing; used by open_addressing_hash_table_core.
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

    localparam int SLOTS    = 1024;
    localparam int KEY_BITS = 31;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int SIZE_W   = IDX_W + 1;
    localparam int CNT_W    = $clog2(KEY_BITS);
    localparam int CFG_W    = 11;
    localparam int SLOT_W   = KEY_BITS + 2;
    localparam int COPY_W   = KEY_BITS + 1;
    localparam int COLL_W   = 32;
    localparam int TH_RESET = 50;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_FULL    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_REBUILT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PM_LINEAR = 2'd0,
        PM_DOUBLE = 2'd1,
        PM_QUAD   = 2'd2
    } probe_mode_t;

    typedef enum logic [1:0] {
        CFG_PROBE_MODE = 2'd0,
        CFG_TABLE_SIZE = 2'd1,
        CFG_THRESHOLD  = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_WIPE,
        S_IDLE,
        S_DIV,
        S_PRB_RD,
        S_PRB_CHK,
        S_CPY_RD,
        S_CPY_WR,
        S_RB_RD,
        S_RB_CHK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/open_addressing_hash_table_core.sv @@
// Sequence: a serial remainder division over the key bits, then a read and a check state
// per probe, then a done state that loads the result, waiting while an older result is
// unread. An update that finds its key runs the division and the probe walk twice.
// Rebuild: copy the m slots (read, write), wipe all SLOTS slots, read and check each copied
// slot, then a division and probe walk per full key.
// Throughput: one request at a time, set by the slot memory walk and the serial divider.
// Reset: a wipe pass marks all SLOTS slots empty; in_ready stays low meanwhile.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module open_addressing_hash_table_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [oaht_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [oaht_pkg::KEY_BITS-1:0] key,
    input  wire logic [oaht_pkg::KEY_BITS-1:0] new_key,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [oaht_pkg::IDX_W-1:0]         slot_index,
    output logic [oaht_pkg::COLL_W-1:0]        collision_count
);

    localparam int IW = oaht_pkg::IDX_W;
    localparam int SW = oaht_pkg::SIZE_W;
    localparam int KW = oaht_pkg::KEY_BITS;
    localparam int CW = oaht_pkg::CNT_W;
    localparam int COPY_W_TOP = oaht_pkg::COPY_W - 1;

    // memories
    logic [oaht_pkg::SLOT_W-1:0] slot_mem [oaht_pkg::SLOTS];
    logic [oaht_pkg::COPY_W-1:0] copy_mem [oaht_pkg::SLOTS];
    logic [oaht_pkg::SLOT_W-1:0] slot_rd_reg;
    logic [oaht_pkg::COPY_W-1:0] copy_rd_reg;
    logic                        slot_we, copy_we;
    logic [IW-1:0]               slot_waddr, slot_raddr, copy_waddr, copy_raddr;
    logic [oaht_pkg::SLOT_W-1:0] slot_wdata;
    logic [oaht_pkg::COPY_W-1:0] copy_wdata;

    // configuration
    logic [1:0]                 probe_mode_reg;
    logic [oaht_pkg::CFG_W-1:0] table_size_reg, rebuild_threshold_reg;

    oaht_pkg::state_t state_reg, state_next;
    logic [1:0]  req_reg, req_next;
    logic [KW-1:0] cur_key_reg, cur_key_next, new_key_reg, new_key_next;
    logic [KW-1:0] div_key_reg, div_key_next;
    logic [CW-1:0] div_cnt_reg, div_cnt_next;
    logic [IW-1:0] rem_m_reg, rem_m_next, rem_m1_reg, rem_m1_next;
    logic [SW-1:0] m_reg, m_next, i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] idx_reg, idx_next, step_reg, step_next;
    logic find_reg, find_next, rebuild_reg, rebuild_next;
    logic [oaht_pkg::CFG_W-1:0] tomb_reg, tomb_next;
    logic [oaht_pkg::COLL_W-1:0] coll_reg, coll_next;
    logic out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg, out_status_next;
    logic [IW-1:0] out_where_reg, out_where_next;
    logic [oaht_pkg::COLL_W-1:0] out_coll_reg, out_coll_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [IW-1:0] res_where_reg, res_where_next;

    logic          accept;
    logic [SW-1:0] m_clamp, m1, shift_m, shift_m1, rem_m_new_w, rem_m1_new_w;
    logic [SW-1:0] idx_sum, idx_adv_w, step_sum, step_adv_w, i_inc, j_inc;
    logic [1:0]    rd_mark;
    logic [KW-1:0] rd_key;
    logic          hit, rd_empty, rd_full, last_probe, div_last, do_rebuild;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == oaht_pkg::S_IDLE);

    assign m_clamp = (table_size_reg < SW'(2)) ? SW'(2) :
                     (table_size_reg > SW'(oaht_pkg::SLOTS)) ? SW'(oaht_pkg::SLOTS) :
                     table_size_reg;
    assign m1 = m_reg - SW'(1);

    // restoring remainder step, one key bit per cycle, MSB first
    assign shift_m      = {rem_m_reg, div_key_reg[KW-1]};
    assign shift_m1     = {rem_m1_reg, div_key_reg[KW-1]};
    assign rem_m_new_w  = (shift_m >= m_reg) ? shift_m - m_reg : shift_m;
    assign rem_m1_new_w = (shift_m1 >= m1) ? shift_m1 - m1 : shift_m1;
    assign div_last     = (div_cnt_reg == CW'(KW - 1));

    assign idx_sum    = {1'b0, idx_reg} + {1'b0, step_reg};
    assign idx_adv_w  = (idx_sum >= m_reg) ? idx_sum - m_reg : idx_sum;
    assign step_sum   = {1'b0, step_reg} + SW'(2);
    assign step_adv_w = (step_sum >= m_reg) ? step_sum - m_reg : step_sum;
    assign i_inc      = i_reg + SW'(1);
    assign j_inc      = j_reg + SW'(1);
    assign last_probe = (i_inc == m_reg);

    assign rd_mark  = slot_rd_reg[oaht_pkg::SLOT_W-1 -: 2];
    assign rd_key   = slot_rd_reg[KW-1:0];
    assign rd_full  = (rd_mark == oaht_pkg::MARK_FULL);
    assign rd_empty = (rd_mark == oaht_pkg::MARK_EMPTY);
    assign hit      = rd_full && (rd_key == cur_key_reg);

    assign do_rebuild = (req_type == oaht_pkg::REQ_DELETE || req_type == oaht_pkg::REQ_UPDATE)
                        && (tomb_reg == rebuild_threshold_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oaht_pkg::S_WIPE:
            begin
                if (j_reg == SW'(oaht_pkg::SLOTS - 1))
                    state_next = rebuild_reg ? oaht_pkg::S_RB_RD : oaht_pkg::S_IDLE;
            end
            oaht_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = do_rebuild ? oaht_pkg::S_CPY_RD : oaht_pkg::S_DIV;
            end
            oaht_pkg::S_DIV:
            begin
                if (div_last)
                    state_next = oaht_pkg::S_PRB_RD;
            end
            oaht_pkg::S_PRB_RD:
                state_next = oaht_pkg::S_PRB_CHK;
            oaht_pkg::S_PRB_CHK:
            begin
                if (find_reg) begin
                    if (hit)
                        state_next = (req_reg == oaht_pkg::REQ_UPDATE) ? oaht_pkg::S_DIV
                                                                       : oaht_pkg::S_DONE;
                    else if (rd_empty || last_probe)
                        state_next = oaht_pkg::S_DONE;
                    else
                        state_next = oaht_pkg::S_PRB_RD;
                end else begin
                    if (!rd_full || last_probe)
                        state_next = rebuild_reg ? oaht_pkg::S_RB_RD : oaht_pkg::S_DONE;
                    else
                        state_next = oaht_pkg::S_PRB_RD;
                end
            end
            oaht_pkg::S_CPY_RD:
                state_next = oaht_pkg::S_CPY_WR;
            oaht_pkg::S_CPY_WR:
                state_next = (j_inc == m_reg) ? oaht_pkg::S_WIPE : oaht_pkg::S_CPY_RD;
            oaht_pkg::S_RB_RD:
                state_next = (j_reg == m_reg) ? oaht_pkg::S_DONE : oaht_pkg::S_RB_CHK;
            oaht_pkg::S_RB_CHK:
                state_next = copy_rd_reg[0] ? oaht_pkg::S_DIV : oaht_pkg::S_RB_RD;
            oaht_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = oaht_pkg::S_IDLE;
            end
            default:
                state_next = oaht_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        req_next        = req_reg;
        cur_key_next    = cur_key_reg;
        new_key_next    = new_key_reg;
        div_key_next    = div_key_reg;
        div_cnt_next    = div_cnt_reg;
        rem_m_next      = rem_m_reg;
        rem_m1_next     = rem_m1_reg;
        m_next          = m_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        find_next       = find_reg;
        rebuild_next    = rebuild_reg;
        tomb_next       = tomb_reg;
        coll_next       = coll_reg;
        res_status_next = res_status_reg;
        res_where_next  = res_where_reg;
        out_status_next = out_status_reg;
        out_where_next  = out_where_reg;
        out_coll_next   = out_coll_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = {oaht_pkg::MARK_FULL, cur_key_reg};
        slot_raddr = idx_reg;
        copy_we    = 1'b0;
        copy_waddr = j_reg[IW-1:0];
        copy_wdata = {rd_key, rd_full};
        copy_raddr = j_reg[IW-1:0];

        case (state_reg)
            oaht_pkg::S_WIPE:
            begin
                slot_we    = 1'b1;
                slot_waddr = j_reg[IW-1:0];
                slot_wdata = {oaht_pkg::MARK_EMPTY, {KW{1'b0}}};
                j_next     = j_inc;
                if (j_reg == SW'(oaht_pkg::SLOTS - 1)) begin
                    j_next    = '0;
                    tomb_next = '0;
                end
            end
            oaht_pkg::S_IDLE:
            begin
                if (accept) begin
                    req_next     = req_type;
                    cur_key_next = key;
                    new_key_next = new_key;
                    m_next       = m_clamp;
                    div_key_next = key;
                    div_cnt_next = '0;
                    rem_m_next   = '0;
                    rem_m1_next  = '0;
                    find_next    = (req_type != oaht_pkg::REQ_INSERT);
                    j_next       = '0;
                    rebuild_next = do_rebuild;
                end
            end
            oaht_pkg::S_DIV:
            begin
                rem_m_next   = rem_m_new_w[IW-1:0];
                rem_m1_next  = rem_m1_new_w[IW-1:0];
                div_key_next = {div_key_reg[KW-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + CW'(1);
                if (div_last) begin
                    i_next   = '0;
                    idx_next = rem_m_new_w[IW-1:0];
                    case (probe_mode_reg)
                        oaht_pkg::PM_DOUBLE:
                            step_next = IW'(1) + rem_m1_new_w[IW-1:0];
                        oaht_pkg::PM_QUAD:
                            step_next = (m_reg == SW'(2)) ? '0 : IW'(2);
                        default:
                            step_next = IW'(1);
                    endcase
                end
            end
            oaht_pkg::S_PRB_CHK:
            begin
                if (find_reg) begin
                    if (hit) begin
                        if (req_reg == oaht_pkg::REQ_SEARCH) begin
                            res_status_next = oaht_pkg::ST_DONE;
                            res_where_next  = idx_reg;
                        end else begin
                            slot_we    = 1'b1;
                            slot_wdata = {oaht_pkg::MARK_DELETED, rd_key};
                            if (tomb_reg != '1)
                                tomb_next = tomb_reg + 1'b1;
                            res_status_next = oaht_pkg::ST_DONE;
                            res_where_next  = idx_reg;
                            if (req_reg == oaht_pkg::REQ_UPDATE) begin
                                // chain into insert of the replacement key
                                cur_key_next = new_key_reg;
                                div_key_next = new_key_reg;
                                div_cnt_next = '0;
                                rem_m_next   = '0;
                                rem_m1_next  = '0;
                                find_next    = 1'b0;
                            end
                        end
                    end else if (rd_empty) begin
                        res_status_next = oaht_pkg::ST_NOT_FOUND;
                        res_where_next  = '0;
                    end else if (last_probe) begin
                        res_status_next = (req_reg == oaht_pkg::REQ_SEARCH)
                                          ? oaht_pkg::ST_NOT_FOUND : oaht_pkg::ST_OVERFLOW;
                        res_where_next  = '0;
                    end else begin
                        i_next   = i_inc;
                        idx_next = idx_adv_w[IW-1:0];
                        if (probe_mode_reg == oaht_pkg::PM_QUAD)
                            step_next = step_adv_w[IW-1:0];
                    end
                end else begin
                    if (!rd_full) begin
                        slot_we = 1'b1;
                        if (rd_mark == oaht_pkg::MARK_DELETED && tomb_reg != '0)
                            tomb_next = tomb_reg - 1'b1;
                        res_status_next = oaht_pkg::ST_DONE;
                        res_where_next  = idx_reg;
                        j_next          = j_inc;
                    end else begin
                        if (coll_reg != '1)
                            coll_next = coll_reg + 1'b1;
                        if (last_probe) begin
                            res_status_next = oaht_pkg::ST_OVERFLOW;
                            res_where_next  = '0;
                            j_next          = j_inc;
                        end else begin
                            i_next   = i_inc;
                            idx_next = idx_adv_w[IW-1:0];
                            if (probe_mode_reg == oaht_pkg::PM_QUAD)
                                step_next = step_adv_w[IW-1:0];
                        end
                    end
                end
            end
            oaht_pkg::S_CPY_RD:
                slot_raddr = j_reg[IW-1:0];
            oaht_pkg::S_CPY_WR:
            begin
                copy_we = 1'b1;
                j_next  = (j_inc == m_reg) ? '0 : j_inc;
            end
            oaht_pkg::S_RB_RD:
            begin
                if (j_reg == m_reg) begin
                    tomb_next       = '0;
                    rebuild_next    = 1'b0;
                    res_status_next = oaht_pkg::ST_REBUILT;
                    res_where_next  = '0;
                end
            end
            oaht_pkg::S_RB_CHK:
            begin
                if (copy_rd_reg[0]) begin
                    cur_key_next = copy_rd_reg[COPY_W_TOP:1];
                    div_key_next = copy_rd_reg[COPY_W_TOP:1];
                    div_cnt_next = '0;
                    rem_m_next   = '0;
                    rem_m1_next  = '0;
                    find_next    = 1'b0;
                end else begin
                    j_next = j_inc;
                end
            end
            oaht_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_where_next  = res_where_reg;
                    out_coll_next   = coll_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (copy_we)
            copy_mem[copy_waddr] <= copy_wdata;
        copy_rd_reg <= copy_mem[copy_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            probe_mode_reg        <= oaht_pkg::PM_LINEAR;
            table_size_reg        <= oaht_pkg::CFG_W'(oaht_pkg::SLOTS);
            rebuild_threshold_reg <= oaht_pkg::CFG_W'(oaht_pkg::TH_RESET);
        end else if (cfg_write) begin
            case (cfg_index)
                oaht_pkg::CFG_PROBE_MODE: probe_mode_reg        <= cfg_data[1:0];
                oaht_pkg::CFG_TABLE_SIZE: table_size_reg        <= cfg_data;
                oaht_pkg::CFG_THRESHOLD:  rebuild_threshold_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= oaht_pkg::S_WIPE;
            j_reg          <= '0;
            rebuild_reg    <= 1'b0;
            find_reg       <= 1'b0;
            tomb_reg       <= '0;
            coll_reg       <= '0;
            out_valid_reg  <= 1'b0;
            req_reg        <= '0;
            div_cnt_reg    <= '0;
            i_reg          <= '0;
            m_reg          <= SW'(oaht_pkg::SLOTS);
        end else begin
            state_reg      <= state_next;
            j_reg          <= j_next;
            rebuild_reg    <= rebuild_next;
            find_reg       <= find_next;
            tomb_reg       <= tomb_next;
            coll_reg       <= coll_next;
            out_valid_reg  <= out_valid_next;
            req_reg        <= req_next;
            div_cnt_reg    <= div_cnt_next;
            i_reg          <= i_next;
            m_reg          <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_key_reg    <= cur_key_next;
        new_key_reg    <= new_key_next;
        div_key_reg    <= div_key_next;
        rem_m_reg      <= rem_m_next;
        rem_m1_reg     <= rem_m1_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_where_reg  <= res_where_next;
        out_status_reg <= out_status_next;
        out_where_reg  <= out_where_next;
        out_coll_reg   <= out_coll_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign slot_index      = out_where_reg;
    assign collision_count = out_coll_reg;

endmodule

`default_nettype wire

@@ dv/open_addressing_hash_table_core_test.sv @@
// Self-checking testbench for open_addressing_hash_table_core: table requests go in
// through a valid/ready driver and each result is checked against an in-bench predictor.
// Depends on oaht_pkg and open_addressing_hash_table_core.
`timescale 1ns / 1ps

module open_addressing_hash_table_core_test;

    typedef struct {
        oaht_pkg::req_t                op;
        logic [oaht_pkg::KEY_BITS-1:0] k;
        logic [oaht_pkg::KEY_BITS-1:0] nk;
    } request_t;

    typedef struct {
        oaht_pkg::status_t           st;
        logic [oaht_pkg::IDX_W-1:0]  slot;
        logic [oaht_pkg::COLL_W-1:0] coll;
    } answer_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [1:0]                    cfg_index;
    logic [oaht_pkg::CFG_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [1:0]                    req_type;
    logic [oaht_pkg::KEY_BITS-1:0] key;
    logic [oaht_pkg::KEY_BITS-1:0] new_key;
    logic                          out_valid;
    logic                          out_ready;
    logic [1:0]                    status;
    logic [oaht_pkg::IDX_W-1:0]    slot_index;
    logic [oaht_pkg::COLL_W-1:0]   collision_count;

    open_addressing_hash_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .key(key), .new_key(new_key),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot_index(slot_index), .collision_count(collision_count)
    );

    // predicted table contents and registers
    logic [oaht_pkg::KEY_BITS-1:0] tbl_keys [oaht_pkg::SLOTS];
    oaht_pkg::mark_t               tbl_marks [oaht_pkg::SLOTS];
    logic [oaht_pkg::CFG_W-1:0]    tombstones;
    logic [oaht_pkg::COLL_W-1:0]   collisions;
    logic [1:0]                    reg_mode;
    logic [oaht_pkg::CFG_W-1:0]    reg_size;
    logic [oaht_pkg::CFG_W-1:0]    reg_thresh;

    request_t                      pending_reqs[$];
    answer_t                       expected_answers[$];
    logic [oaht_pkg::KEY_BITS-1:0] key_pool[$];
    request_t                      in_flight;
    int                            errors;
    int                            send_gap;
    int                            recv_stall;
    bit                            no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned slots_in_use();
        int unsigned m;
        m = 32'(reg_size);
        if (m < 2) m = 2;
        if (m > oaht_pkg::SLOTS) m = oaht_pkg::SLOTS;
        return m;
    endfunction

    function automatic int unsigned probe_slot(longint unsigned k, longint unsigned i,
                                               int unsigned m);
        longint unsigned h;
        h = k % m;
        if (reg_mode == oaht_pkg::PM_DOUBLE) return 32'((h + i * (1 + k % (m - 1))) % m);
        if (reg_mode == oaht_pkg::PM_QUAD) return 32'((h + i + i * i) % m);
        return 32'((k + i) % m);
    endfunction

    function automatic void bump_collisions();
        if (collisions != '1) collisions = collisions + 1'b1;
    endfunction

    function automatic bit place_key(logic [oaht_pkg::KEY_BITS-1:0] k, int unsigned m,
                                     output int unsigned where);
        longint unsigned i;
        int unsigned idx;
        i = 0;
        idx = probe_slot(64'(k), 0, m);
        where = 0;
        while (tbl_marks[idx] == oaht_pkg::MARK_FULL)
        begin
            i++;
            bump_collisions();
            if (i == m) return 0;
            idx = probe_slot(64'(k), i, m);
        end
        if (tbl_marks[idx] == oaht_pkg::MARK_DELETED && tombstones > 0)
            tombstones = tombstones - 1'b1;
        tbl_keys[idx] = k;
        tbl_marks[idx] = oaht_pkg::MARK_FULL;
        where = idx;
        return 1;
    endfunction

    // 0 found, 1 stopped at empty, 2 probes exhausted
    function automatic int lookup_key(logic [oaht_pkg::KEY_BITS-1:0] k, int unsigned m,
                                      output int unsigned where);
        int unsigned idx;
        where = 0;
        for (longint unsigned i = 0; i < m; i++)
        begin
            idx = probe_slot(64'(k), i, m);
            if (tbl_marks[idx] == oaht_pkg::MARK_FULL && tbl_keys[idx] == k)
            begin
                where = idx;
                return 0;
            end
            if (tbl_marks[idx] == oaht_pkg::MARK_EMPTY) return 1;
        end
        return 2;
    endfunction

    function automatic void rebuild_table(int unsigned m);
        logic [oaht_pkg::KEY_BITS-1:0] kept[$];
        int unsigned scratch;
        for (int j = 0; j < m; j++)
            if (tbl_marks[j] == oaht_pkg::MARK_FULL) kept.push_back(tbl_keys[j]);
        for (int j = 0; j < oaht_pkg::SLOTS; j++) tbl_marks[j] = oaht_pkg::MARK_EMPTY;
        tombstones = '0;
        foreach (kept[j]) void'(place_key(kept[j], m, scratch));
        tombstones = '0;
    endfunction

    function automatic answer_t predict_answer(request_t r);
        answer_t a;
        int unsigned m;
        int unsigned where;
        int found;
        m = slots_in_use();
        a.st = oaht_pkg::ST_DONE;
        where = 0;
        if (r.op == oaht_pkg::REQ_INSERT)
        begin
            if (!place_key(r.k, m, where)) a.st = oaht_pkg::ST_OVERFLOW;
        end
        else if (r.op == oaht_pkg::REQ_SEARCH)
        begin
            if (lookup_key(r.k, m, where) != 0) a.st = oaht_pkg::ST_NOT_FOUND;
        end
        else if (tombstones == reg_thresh)
        begin
            rebuild_table(m);
            a.st = oaht_pkg::ST_REBUILT;
        end
        else
        begin
            found = lookup_key(r.k, m, where);
            if (found == 1) a.st = oaht_pkg::ST_NOT_FOUND;
            else if (found == 2) a.st = oaht_pkg::ST_OVERFLOW;
            else
            begin
                tbl_marks[where] = oaht_pkg::MARK_DELETED;
                if (tombstones != '1) tombstones = tombstones + 1'b1;
                if (r.op == oaht_pkg::REQ_UPDATE && !place_key(r.nk, m, where))
                    a.st = oaht_pkg::ST_OVERFLOW;
            end
        end
        a.slot = (a.st == oaht_pkg::ST_DONE) ? where[oaht_pkg::IDX_W-1:0] : '0;
        a.coll = collisions;
        return a;
    endfunction

    // driver: present pending requests, predict each one on its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= '0;
            key      <= '0;
            new_key  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_answers.push_back(predict_answer(in_flight));
            if (in_valid && !in_ready)
            begin
                // hold the current request
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_flight = pending_reqs.pop_front();
                req_type <= in_flight.op;
                key      <= in_flight.k;
                new_key  <= in_flight.nk;
                in_valid <= 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 9);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: random backpressure, compare each transfer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        logic next_ready;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            next_ready = 1'b1;
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%t: unexpected result status=%0d slot=%0d coll=%0d",
                             $time, status, slot_index, collision_count);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%t: status expected %0d actual %0d", $time, want.st, status);
                        errors++;
                    end
                    if (slot_index !== want.slot)
                    begin
                        $display("%t: slot_index expected %0d actual %0d",
                                 $time, want.slot, slot_index);
                        errors++;
                    end
                    if (collision_count !== want.coll)
                    begin
                        $display("%t: collision_count expected %0d actual %0d",
                                 $time, want.coll, collision_count);
                        errors++;
                    end
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                next_ready = 1'b0;
            end
            out_ready <= next_ready;
        end
    end

    task automatic write_reg(oaht_pkg::cfg_index_t idx, logic [oaht_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            oaht_pkg::CFG_PROBE_MODE: reg_mode = val[1:0];
            oaht_pkg::CFG_TABLE_SIZE: reg_size = val;
            default:                  reg_thresh = val;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_table(logic [1:0] mode, logic [oaht_pkg::CFG_W-1:0] size,
                             logic [oaht_pkg::CFG_W-1:0] thresh);
        write_reg(oaht_pkg::CFG_PROBE_MODE, oaht_pkg::CFG_W'(mode));
        write_reg(oaht_pkg::CFG_TABLE_SIZE, size);
        write_reg(oaht_pkg::CFG_THRESHOLD, thresh);
    endtask

    task automatic queue_req(oaht_pkg::req_t op, logic [oaht_pkg::KEY_BITS-1:0] k,
                             logic [oaht_pkg::KEY_BITS-1:0] nk);
        request_t r;
        r.op = op;
        r.k  = k;
        r.nk = nk;
        pending_reqs.push_back(r);
    endtask

    // block until every request is sent and answered; sample after the edge settles
    task automatic drain();
        do @(negedge clk);
        while (pending_reqs.size() > 0 || in_valid || expected_answers.size() > 0);
    endtask

    function automatic logic [oaht_pkg::KEY_BITS-1:0] pick_key();
        logic [oaht_pkg::KEY_BITS-1:0] k;
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 6)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if ($urandom_range(0, 1)) k = oaht_pkg::KEY_BITS'($urandom);
        else k = oaht_pkg::KEY_BITS'($urandom_range(0, 63));
        return k;
    endfunction

    task automatic queue_random(int count);
        request_t r;
        int dice;
        for (int n = 0; n < count; n++)
        begin
            dice = $urandom_range(0, 99);
            r.op = dice < 40 ? oaht_pkg::REQ_INSERT : dice < 60 ? oaht_pkg::REQ_DELETE :
                   dice < 75 ? oaht_pkg::REQ_UPDATE : oaht_pkg::REQ_SEARCH;
            r.k  = pick_key();
            r.nk = pick_key();
            if (r.op == oaht_pkg::REQ_INSERT) key_pool.push_back(r.k);
            if (r.op == oaht_pkg::REQ_UPDATE) key_pool.push_back(r.nk);
            if (key_pool.size() > 48) void'(key_pool.pop_front());
            pending_reqs.push_back(r);
        end
    endtask

    initial
    begin
        logic [oaht_pkg::CFG_W-1:0] size;
        logic [oaht_pkg::CFG_W-1:0] thresh;
        errors     = 0;
        no_idle    = 1'b0;
        reg_mode   = oaht_pkg::PM_LINEAR;
        reg_size   = oaht_pkg::CFG_W'(oaht_pkg::SLOTS);
        reg_thresh = oaht_pkg::CFG_W'(oaht_pkg::TH_RESET);
        tombstones = '0;
        collisions = '0;
        for (int j = 0; j < oaht_pkg::SLOTS; j++) tbl_marks[j] = oaht_pkg::MARK_EMPTY;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: extreme keys, duplicates, misses
        queue_req(oaht_pkg::REQ_INSERT, '0, '0);
        queue_req(oaht_pkg::REQ_INSERT, '1, '0);
        queue_req(oaht_pkg::REQ_INSERT, '0, '1);
        queue_req(oaht_pkg::REQ_SEARCH, '1, '0);
        queue_req(oaht_pkg::REQ_UPDATE, '1, 31'h2AAA_AAAA);
        queue_req(oaht_pkg::REQ_DELETE, '0, '0);
        queue_req(oaht_pkg::REQ_SEARCH, '0, '0);
        queue_req(oaht_pkg::REQ_SEARCH, 31'h5555_5555, '0);
        queue_req(oaht_pkg::REQ_DELETE, 31'd77, '0);
        drain();

        // two slots, rebuild at one tombstone: overflow, exhaustion, rebuild
        set_table(oaht_pkg::PM_LINEAR, 11'd2, 11'd1);
        queue_req(oaht_pkg::REQ_INSERT, 31'd5, '0);
        queue_req(oaht_pkg::REQ_INSERT, 31'd6, '0);
        queue_req(oaht_pkg::REQ_INSERT, 31'd7, '0);
        queue_req(oaht_pkg::REQ_SEARCH, 31'd9, '0);
        queue_req(oaht_pkg::REQ_DELETE, 31'd9, '0);
        queue_req(oaht_pkg::REQ_UPDATE, 31'd9, 31'd3);
        queue_req(oaht_pkg::REQ_DELETE, 31'd5, '0);
        queue_req(oaht_pkg::REQ_DELETE, 31'd6, '0);
        queue_req(oaht_pkg::REQ_UPDATE, 31'd6, 31'd8);
        queue_req(oaht_pkg::REQ_INSERT, 31'd4, '0);
        queue_req(oaht_pkg::REQ_UPDATE, 31'd8, 31'd10);
        drain();

        // unused probe mode, out-of-range sizes
        set_table(2'd3, 11'd0, 11'd0);
        queue_req(oaht_pkg::REQ_INSERT, 31'd1, '0);
        queue_req(oaht_pkg::REQ_DELETE, 31'd1, '0);
        drain();
        set_table(oaht_pkg::PM_QUAD, 11'h7FF, 11'd1024);
        queue_random(20);
        drain();

        for (int phase = 0; phase < 15; phase++)
        begin
            no_idle = (phase % 4 == 3);
            size = ($urandom_range(0, 9) == 0) ? 11'd1024
                                               : oaht_pkg::CFG_W'($urandom_range(2, 40));
            thresh = ($urandom_range(0, 7) == 0) ? 11'd1024
                                                 : oaht_pkg::CFG_W'($urandom_range(1, 8));
            set_table(2'($urandom_range(0, 3)), size, thresh);
            queue_random(40);
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("open_addressing_hash_table_core test passed");
        else
            $display("open_addressing_hash_table_core test failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("open_addressing_hash_table_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/oaht_pkg.sv
hw/rtl/open_addressing_hash_table_core.sv
dv/open_addressing_hash_table_core_test.sv
